>>> rtl/rit_pkg.sv
// Shared types, widths and helpers for the reprojection inlier test.
`default_nettype none

package rit_pkg;

    // Field formats
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int INDEX_WIDTH = 24;

    // Configuration port
    localparam int NUM_REGS       = 7;
    localparam int MAT_REGS       = 6;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 64;
    localparam int HALF_WIDTH     = 32;
    localparam int LIMIT_WIDTH    = 48;
    localparam int LIMIT_FRAC     = 32;

    // Datapath widths
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;
    localparam int TERM_WIDTH = PROD_WIDTH - FRAC_BITS;
    localparam int CAM_WIDTH  = TERM_WIDTH + 2;
    localparam int MAG_WIDTH  = CAM_WIDTH;
    localparam int QUO_BITS   = 61;
    localparam int QUO_WIDTH  = QUO_BITS + 1;
    localparam int SAT_SHIFT  = QUO_BITS - FRAC_BITS;
    localparam int DIFF_WIDTH = QUO_WIDTH + 2;
    localparam int CAP_EXP    = 31;
    localparam int CAP_WIDTH  = CAP_EXP + 1;
    localparam int SQ_WIDTH   = 2 * CAP_WIDTH;
    localparam int SQ_SHIFT   = LIMIT_FRAC - 2 * FRAC_BITS;
    localparam int LIM_SHIFT  = 2 * FRAC_BITS - LIMIT_FRAC;

    // Pipeline depths
    localparam int DIV_LATENCY = QUO_BITS + 1;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_WIDTH = ((6 * COORD_WIDTH + INDEX_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((1 + INDEX_WIDTH + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [TERM_WIDTH-1:0]  term_t;
    typedef logic signed [CAM_WIDTH-1:0]   cam_t;
    typedef logic [MAG_WIDTH-1:0]          mag_t;
    typedef logic [MAG_WIDTH:0]            trial_t;
    typedef logic [QUO_BITS-1:0]           qbits_t;
    typedef logic [QUO_WIDTH-1:0]          quo_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic [CAP_WIDTH-1:0]          cap_t;
    typedef logic [SQ_WIDTH-1:0]           sq_t;
    typedef logic [LIMIT_WIDTH-1:0]        limit_t;
    typedef logic [INDEX_WIDTH-1:0]        index_t;
    typedef logic [MAT_REGS-1:0][CFG_DATA_WIDTH-1:0] mat_t;

    localparam quo_t QSAT = quo_t'(1) << QUO_BITS;

    // Register indexes on the configuration port
    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_ROW0_COLS01    = 3'd0,
        REG_ROW0_COLS23    = 3'd1,
        REG_ROW1_COLS01    = 3'd2,
        REG_ROW1_COLS23    = 3'd3,
        REG_ROW2_COLS01    = 3'd4,
        REG_ROW2_COLS23    = 3'd5,
        REG_RESIDUAL_LIMIT = 3'd6
    } cfg_reg_t;

    // Item tag that travels with the data
    typedef struct packed {
        logic   valid;
        logic   reject;
        index_t index;
    } tag_t;

    // Quotient signs
    typedef struct packed {
        logic neg_xq;
        logic neg_yq;
        logic neg_uq;
        logic neg_vq;
    } sign_t;

    // Tag and signs held across the dividers
    typedef struct packed {
        tag_t  tag;
        sign_t sign;
    } side_t;

    // Finished result
    typedef struct packed {
        logic   valid;
        logic   inlier;
        index_t index;
    } res_t;

    // Left shift that saturates to all ones
    function automatic sq_t sat_shl(input sq_t v, input int s);
        sq_t ones;
        ones = '1;
        if (s <= 0) return v;
        if ((v & ~(ones >> s)) != '0) return ones;
        return v << s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rit_transform.sv
// Camera transform: products, floored sums, then magnitudes and reject check.
`default_nettype none

module rit_transform (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire rit_pkg::mat_t   mat,
    input  wire rit_pkg::coord_t pt_x,
    input  wire rit_pkg::coord_t pt_y,
    input  wire rit_pkg::coord_t pt_z,
    input  wire rit_pkg::coord_t ray_u,
    input  wire rit_pkg::coord_t ray_v,
    input  wire rit_pkg::coord_t ray_w,
    input  wire rit_pkg::tag_t   tag_in,
    output rit_pkg::tag_t        tag_out,
    output rit_pkg::sign_t       sign_out,
    output rit_pkg::mag_t        mag_x,
    output rit_pkg::mag_t        mag_y,
    output rit_pkg::mag_t        mag_z,
    output rit_pkg::mag_t        mag_u,
    output rit_pkg::mag_t        mag_v,
    output rit_pkg::mag_t        mag_w
);

    rit_pkg::coord_t coef [3][3];
    rit_pkg::coord_t trans [3];
    rit_pkg::coord_t pt [3];

    rit_pkg::prod_t  prod_reg [3][3];
    rit_pkg::coord_t trans_reg [3];
    rit_pkg::coord_t u1_reg, v1_reg, w1_reg;
    rit_pkg::tag_t   tag1_reg;

    rit_pkg::cam_t   cam_next [3];
    rit_pkg::cam_t   cam_reg [3];
    rit_pkg::coord_t u2_reg, v2_reg, w2_reg;
    rit_pkg::tag_t   tag2_reg;

    rit_pkg::tag_t   tag3_next;
    rit_pkg::tag_t   tag3_reg;
    rit_pkg::sign_t  sign3_reg;
    rit_pkg::mag_t   mx_reg, my_reg, mz_reg, mu_reg, mv_reg, mw_reg;

    // Split the matrix registers into coefficients
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            coef[r][0] = mat[2*r][rit_pkg::COORD_WIDTH-1:0];
            coef[r][1] = rit_pkg::coord_t'(mat[2*r] >> rit_pkg::HALF_WIDTH);
            coef[r][2] = mat[2*r+1][rit_pkg::COORD_WIDTH-1:0];
            trans[r]   = rit_pkg::coord_t'(mat[2*r+1] >> rit_pkg::HALF_WIDTH);
        end
        pt[0] = pt_x;
        pt[1] = pt_y;
        pt[2] = pt_z;
    end

    // Stage 1: nine exact products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= coef[r][c] * pt[c];
                end
                trans_reg[r] <= trans[r];
            end
            u1_reg <= ray_u;
            v1_reg <= ray_v;
            w1_reg <= ray_w;
        end
    end

    // Stage 2: floor each product and add the translation
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            cam_next[r] = rit_pkg::cam_t'(rit_pkg::term_t'(prod_reg[r][0] >>> rit_pkg::FRAC_BITS))
                        + rit_pkg::cam_t'(rit_pkg::term_t'(prod_reg[r][1] >>> rit_pkg::FRAC_BITS))
                        + rit_pkg::cam_t'(rit_pkg::term_t'(prod_reg[r][2] >>> rit_pkg::FRAC_BITS))
                        + rit_pkg::cam_t'(trans_reg[r]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                cam_reg[r] <= cam_next[r];
            end
            u2_reg <= u1_reg;
            v2_reg <= v1_reg;
            w2_reg <= w1_reg;
        end
    end

    // Stage 3: reject points on or behind the camera and rays at infinity
    always_comb begin
        tag3_next        = tag2_reg;
        tag3_next.reject = cam_reg[2][rit_pkg::CAM_WIDTH-1] || (cam_reg[2] == '0)
                        || (w2_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg <= rit_pkg::mag_t'(cam_reg[0] < 0 ? -cam_reg[0] : cam_reg[0]);
            my_reg <= rit_pkg::mag_t'(cam_reg[1] < 0 ? -cam_reg[1] : cam_reg[1]);
            mz_reg <= rit_pkg::mag_t'(cam_reg[2] < 0 ? -cam_reg[2] : cam_reg[2]);
            mu_reg <= rit_pkg::mag_t'(u2_reg < 0 ? -rit_pkg::cam_t'(u2_reg)
                                                 : rit_pkg::cam_t'(u2_reg));
            mv_reg <= rit_pkg::mag_t'(v2_reg < 0 ? -rit_pkg::cam_t'(v2_reg)
                                                 : rit_pkg::cam_t'(v2_reg));
            mw_reg <= rit_pkg::mag_t'(w2_reg < 0 ? -rit_pkg::cam_t'(w2_reg)
                                                 : rit_pkg::cam_t'(w2_reg));
            sign3_reg.neg_xq <= cam_reg[0][rit_pkg::CAM_WIDTH-1]
                              ^ cam_reg[2][rit_pkg::CAM_WIDTH-1];
            sign3_reg.neg_yq <= cam_reg[1][rit_pkg::CAM_WIDTH-1]
                              ^ cam_reg[2][rit_pkg::CAM_WIDTH-1];
            sign3_reg.neg_uq <= u2_reg[rit_pkg::COORD_WIDTH-1] ^ w2_reg[rit_pkg::COORD_WIDTH-1];
            sign3_reg.neg_vq <= v2_reg[rit_pkg::COORD_WIDTH-1] ^ w2_reg[rit_pkg::COORD_WIDTH-1];
        end
    end

    // Advance the item tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else if (en) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag3_next;
        end
    end

    assign tag_out  = tag3_reg;
    assign sign_out = sign3_reg;
    assign mag_x    = mx_reg;
    assign mag_y    = my_reg;
    assign mag_z    = mz_reg;
    assign mag_u    = mu_reg;
    assign mag_v    = mv_reg;
    assign mag_w    = mw_reg;

endmodule

`default_nettype wire

>>> rtl/rit_divider.sv
// Pipelined restoring divider: saturating num * 2^FRAC_BITS / den, one bit per stage.
`default_nettype none

module rit_divider (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire rit_pkg::mag_t num_mag,
    input  wire rit_pkg::mag_t den_mag,
    output rit_pkg::quo_t      quo
);

    rit_pkg::qbits_t rest_init;
    rit_pkg::mag_t   rem_init;

    rit_pkg::mag_t   rem_reg  [rit_pkg::QUO_BITS];
    rit_pkg::mag_t   den_reg  [rit_pkg::QUO_BITS];
    rit_pkg::qbits_t rest_reg [rit_pkg::QUO_BITS];
    rit_pkg::qbits_t quo_reg  [rit_pkg::DIV_LATENCY];
    logic            sat_reg  [rit_pkg::DIV_LATENCY];

    rit_pkg::trial_t trial    [rit_pkg::QUO_BITS];
    logic            ge       [rit_pkg::QUO_BITS];
    rit_pkg::mag_t   rem_next [rit_pkg::QUO_BITS-1];
    rit_pkg::qbits_t quo_next [rit_pkg::QUO_BITS];

    // Dividend bits still to bring down, and the leading remainder
    assign rest_init = rit_pkg::qbits_t'({num_mag, {rit_pkg::FRAC_BITS{1'b0}}});
    assign rem_init  = num_mag >> rit_pkg::SAT_SHIFT;

    // One quotient bit per stage
    always_comb begin
        for (int s = 0; s < rit_pkg::QUO_BITS; s++) begin
            trial[s]    = {rem_reg[s], rest_reg[s][rit_pkg::QUO_BITS-1]};
            ge[s]       = trial[s] >= {1'b0, den_reg[s]};
            quo_next[s] = {quo_reg[s][rit_pkg::QUO_BITS-2:0], ge[s]};
        end
        for (int s = 0; s < rit_pkg::QUO_BITS - 1; s++) begin
            rem_next[s] = ge[s] ? rit_pkg::mag_t'(trial[s] - {1'b0, den_reg[s]})
                                : rit_pkg::mag_t'(trial[s]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= rem_init;
            den_reg[0]  <= den_mag;
            rest_reg[0] <= rest_init;
            quo_reg[0]  <= '0;
            sat_reg[0]  <= rem_init >= den_mag;
            for (int s = 0; s < rit_pkg::QUO_BITS; s++) begin
                quo_reg[s+1] <= quo_next[s];
                sat_reg[s+1] <= sat_reg[s];
            end
            for (int s = 0; s < rit_pkg::QUO_BITS - 1; s++) begin
                rem_reg[s+1]  <= rem_next[s];
                den_reg[s+1]  <= den_reg[s];
                rest_reg[s+1] <= rest_reg[s] << 1;
            end
        end
    end

    // Clamp the magnitude at the saturation value
    assign quo = sat_reg[rit_pkg::QUO_BITS] ? rit_pkg::QSAT
                                            : rit_pkg::quo_t'(quo_reg[rit_pkg::QUO_BITS]);

endmodule

`default_nettype wire

>>> rtl/rit_residual.sv
// Residual: signed quotients, differences, capped squares and the limit compare.
`default_nettype none

module rit_residual (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire rit_pkg::quo_t   quo_x,
    input  wire rit_pkg::quo_t   quo_y,
    input  wire rit_pkg::quo_t   quo_u,
    input  wire rit_pkg::quo_t   quo_v,
    input  wire rit_pkg::side_t  side_in,
    input  wire rit_pkg::limit_t limit,
    output rit_pkg::res_t        res
);

    localparam rit_pkg::diff_t DCAP = rit_pkg::diff_t'(1) << rit_pkg::CAP_EXP;

    rit_pkg::diff_t sx_reg, sy_reg, su_reg, sv_reg;
    rit_pkg::diff_t dx_reg, dy_reg;
    rit_pkg::diff_t ax_next, ay_next;
    rit_pkg::cap_t  cx_reg, cy_reg;
    rit_pkg::sq_t   qx_reg, qy_reg;
    rit_pkg::sq_t   sum_al, lim_al;
    rit_pkg::tag_t  tag_reg [4];
    rit_pkg::res_t  res_reg;

    // Stage 1: apply quotient signs
    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= side_in.sign.neg_xq ? -rit_pkg::diff_t'(quo_x) : rit_pkg::diff_t'(quo_x);
            sy_reg <= side_in.sign.neg_yq ? -rit_pkg::diff_t'(quo_y) : rit_pkg::diff_t'(quo_y);
            su_reg <= side_in.sign.neg_uq ? -rit_pkg::diff_t'(quo_u) : rit_pkg::diff_t'(quo_u);
            sv_reg <= side_in.sign.neg_vq ? -rit_pkg::diff_t'(quo_v) : rit_pkg::diff_t'(quo_v);
        end
    end

    // Stage 2: ray minus point
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= su_reg - sx_reg;
            dy_reg <= sv_reg - sy_reg;
        end
    end

    // Stage 3: magnitude, capped ahead of squaring
    assign ax_next = dx_reg < 0 ? -dx_reg : dx_reg;
    assign ay_next = dy_reg < 0 ? -dy_reg : dy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg <= ($unsigned(ax_next) > $unsigned(DCAP)) ? rit_pkg::cap_t'(DCAP)
                                                             : ax_next[rit_pkg::CAP_WIDTH-1:0];
            cy_reg <= ($unsigned(ay_next) > $unsigned(DCAP)) ? rit_pkg::cap_t'(DCAP)
                                                             : ay_next[rit_pkg::CAP_WIDTH-1:0];
        end
    end

    // Stage 4: squares
    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg <= rit_pkg::sq_t'(cx_reg) * rit_pkg::sq_t'(cx_reg);
            qy_reg <= rit_pkg::sq_t'(cy_reg) * rit_pkg::sq_t'(cy_reg);
        end
    end

    // Stage 5: align fraction bits and compare against the limit
    assign sum_al = rit_pkg::sat_shl(qx_reg + qy_reg, rit_pkg::SQ_SHIFT);
    assign lim_al = rit_pkg::sat_shl(rit_pkg::sq_t'(limit), rit_pkg::LIM_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                tag_reg[i] <= '0;
            end
            res_reg <= '0;
        end else if (en) begin
            tag_reg[0] <= side_in.tag;
            for (int i = 0; i < 3; i++) begin
                tag_reg[i+1] <= tag_reg[i];
            end
            res_reg.valid  <= tag_reg[3].valid;
            res_reg.inlier <= !tag_reg[3].reject && (sum_al < lim_al);
            res_reg.index  <= tag_reg[3].index;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> rtl/reprojection_inlier_test_top.sv
// Top level of the reprojection inlier test: config registers, pipeline, output skid.
`default_nettype none

// Streams one correspondence per cycle while the output is not stalled. Each
// item passes a 3-stage camera transform, four 62-stage restoring dividers
// side by side (one quotient bit per stage), a 5-stage residual unit and an
// output register. The whole pipeline advances together; when the consumer
// stalls, one more result lands in a skid register and then s_tready drops
// until the output drains. Configuration writes take effect at once and
// belong in idle periods.
module reprojection_inlier_test_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [rit_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  wire logic [rit_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // point_x, point_y, point_z, ray_u, ray_v, ray_w, point_index
    input  wire logic [rit_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // is_inlier, result_index, zero pad
    output logic [rit_pkg::M_TDATA_WIDTH-1:0]        m_tdata
);

    localparam int CW = rit_pkg::COORD_WIDTH;

    rit_pkg::mat_t    mat_reg;
    rit_pkg::limit_t  limit_reg;

    logic             en;
    rit_pkg::tag_t    tag_in;
    rit_pkg::tag_t    tag_t3;
    rit_pkg::sign_t   sign_t3;
    rit_pkg::mag_t    mag_x, mag_y, mag_z, mag_u, mag_v, mag_w;
    rit_pkg::quo_t    quo_x, quo_y, quo_u, quo_v;
    rit_pkg::side_t   side_reg [rit_pkg::DIV_LATENCY];
    rit_pkg::res_t    res;

    logic             take;
    logic             arrive;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [rit_pkg::INDEX_WIDTH:0] out_data_reg;
    logic [rit_pkg::INDEX_WIDTH:0] skid_data_reg;
    logic [rit_pkg::INDEX_WIDTH:0] res_data;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg   <= '0;
            limit_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                rit_pkg::REG_ROW0_COLS01, rit_pkg::REG_ROW0_COLS23,
                rit_pkg::REG_ROW1_COLS01, rit_pkg::REG_ROW1_COLS23,
                rit_pkg::REG_ROW2_COLS01, rit_pkg::REG_ROW2_COLS23: begin
                    mat_reg[cfg_addr] <= cfg_wdata;
                end
                rit_pkg::REG_RESIDUAL_LIMIT: begin
                    limit_reg <= cfg_wdata[rit_pkg::LIMIT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the pipeline unless the skid register is holding a result
    assign en       = !skid_valid_reg;
    assign s_tready = en && aresetn;

    assign tag_in.valid  = s_tvalid;
    assign tag_in.reject = 1'b0;
    assign tag_in.index  = s_tdata[6*CW +: rit_pkg::INDEX_WIDTH];

    rit_transform u_transform (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .mat      (mat_reg),
        .pt_x     (s_tdata[0*CW +: CW]),
        .pt_y     (s_tdata[1*CW +: CW]),
        .pt_z     (s_tdata[2*CW +: CW]),
        .ray_u    (s_tdata[3*CW +: CW]),
        .ray_v    (s_tdata[4*CW +: CW]),
        .ray_w    (s_tdata[5*CW +: CW]),
        .tag_in   (tag_in),
        .tag_out  (tag_t3),
        .sign_out (sign_t3),
        .mag_x    (mag_x),
        .mag_y    (mag_y),
        .mag_z    (mag_z),
        .mag_u    (mag_u),
        .mag_v    (mag_v),
        .mag_w    (mag_w)
    );

    rit_divider u_div_x (.aclk(aclk), .en(en), .num_mag(mag_x), .den_mag(mag_z), .quo(quo_x));
    rit_divider u_div_y (.aclk(aclk), .en(en), .num_mag(mag_y), .den_mag(mag_z), .quo(quo_y));
    rit_divider u_div_u (.aclk(aclk), .en(en), .num_mag(mag_u), .den_mag(mag_w), .quo(quo_u));
    rit_divider u_div_v (.aclk(aclk), .en(en), .num_mag(mag_v), .den_mag(mag_w), .quo(quo_v));

    // Delay tags and signs alongside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rit_pkg::DIV_LATENCY; i++) begin
                side_reg[i] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= '{tag: tag_t3, sign: sign_t3};
            for (int i = 0; i < rit_pkg::DIV_LATENCY - 1; i++) begin
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    rit_residual u_residual (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .quo_x   (quo_x),
        .quo_y   (quo_y),
        .quo_u   (quo_u),
        .quo_v   (quo_v),
        .side_in (side_reg[rit_pkg::DIV_LATENCY-1]),
        .limit   (limit_reg),
        .res     (res)
    );

    // Output register with skid stage
    assign take     = m_tready || !out_valid_reg;
    assign arrive   = en && res.valid;
    assign res_data = {res.index, res.inlier};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= arrive;
            end
        end else if (arrive) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end
        if (!take && arrive) begin
            skid_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rit_pkg::M_TDATA_WIDTH'(out_data_reg);

    // The skid register only fills behind a waiting result
    ap_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    // The skid register fills only when the output was stalled
    ap_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without a stalled output");

    // A held skid result is kept until the output can take it
    ap_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("skid result dropped during a stall");

endmodule

`default_nettype wire
